[rtl/uv_sphere_vertex_generator_unit_macros.svh]
// assertion macros used by the uv sphere vertex generator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef UV_SPHERE_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define UVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/uvs_pkg.sv]
// shared types and constants of the uv sphere vertex generator
// no dependencies
package uvs_pkg;

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_SECTORS = 2'd1,
    REG_STACKS  = 2'd2
  } cfg_reg_t;

  localparam int TURN_BITS    = 17;
  localparam int OUT_FRAC     = 16;
  localparam int TWO_PI_SPLIT = 18;
  localparam int PI_HI_BITS   = 17;

  localparam logic [TURN_BITS-1:0] QUARTER_TURN = 17'h08000;

  localparam longint TWO_PI_Q32 = 64'd26986075409;
  localparam longint GAIN_Q30   = 64'd652032874;

  localparam longint ATAN_Q30 [25] = '{
    843314857, 497837829, 263043837, 133525158, 67021687,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63
  };

  // round half up from q30 to f fraction bits
  function automatic longint q30_to_fix(longint v, int f);
    return (v + (longint'(1) << (29 - f))) >>> (30 - f);
  endfunction

endpackage

[rtl/uvs_cordic.sv]
// pipelined sine/cosine of an angle given in turns, one cordic iteration per stage
// depends on uvs_pkg
module uvs_cordic #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [uvs_pkg::TURN_BITS-1:0]      turn,
  output logic signed [FRAC_BITS+1:0]        cos_q,
  output logic signed [FRAC_BITS+1:0]        sin_q
);
  import uvs_pkg::*;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  localparam int W        = FRAC_BITS + 3;
  localparam int REM_BITS = TURN_BITS - 2;
  localparam int SH       = 32 + TURN_BITS - FRAC_BITS;
  localparam int PHI_W    = REM_BITS + PI_HI_BITS;
  localparam int PLO_W    = REM_BITS + TWO_PI_SPLIT;
  localparam int SUM_W    = PHI_W + TWO_PI_SPLIT + 1;

  localparam logic [PI_HI_BITS-1:0]   PI_HI = PI_HI_BITS'(TWO_PI_Q32 >> TWO_PI_SPLIT);
  localparam logic [TWO_PI_SPLIT-1:0] PI_LO = TWO_PI_SPLIT'(TWO_PI_Q32);
  localparam logic [SUM_W-1:0]        Z_HALF = SUM_W'(longint'(1) << (SH - 1));
  localparam logic signed [W-1:0]     X_INIT = W'(q30_to_fix(GAIN_Q30, FRAC_BITS));
  localparam logic signed [W-1:0]     ONE = W'(longint'(1) << FRAC_BITS);

  logic [PHI_W-1:0]         phi_r;
  logic [PLO_W-1:0]         plo_r;
  quad_t                    quad_r [0:FRAC_BITS+1];
  logic signed [W-1:0]      x_r [0:FRAC_BITS];
  logic signed [W-1:0]      y_r [0:FRAC_BITS];
  logic signed [W-1:0]      z_r [0:FRAC_BITS];
  logic [SUM_W-1:0]         z_sum;
  logic signed [W-1:0]      xc;
  logic signed [W-1:0]      yc;
  logic signed [W-1:0]      c_nxt;
  logic signed [W-1:0]      s_nxt;
  logic signed [FRAC_BITS+1:0] cos_r;
  logic signed [FRAC_BITS+1:0] sin_r;

  // angle to radians, constant split in two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      phi_r     <= PHI_W'(turn[REM_BITS-1:0]) * PHI_W'(PI_HI);
      plo_r     <= PLO_W'(turn[REM_BITS-1:0]) * PLO_W'(PI_LO);
      quad_r[0] <= quad_t'(turn[TURN_BITS-1 -: 2]);
    end
  end

  assign z_sum = (SUM_W'(phi_r) << TWO_PI_SPLIT) + SUM_W'(plo_r) + Z_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= X_INIT;
      y_r[0]    <= '0;
      z_r[0]    <= W'(z_sum >> SH);
      quad_r[1] <= quad_r[0];
    end
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_iter
    localparam logic signed [W-1:0] ATAN_K = W'(q30_to_fix(ATAN_Q30[k], FRAC_BITS));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][W-1]) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN_K;
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN_K;
        end
        quad_r[k+2] <= quad_r[k+1];
      end
    end
  end

  always_comb begin
    xc = (x_r[FRAC_BITS] > ONE) ? ONE : ((x_r[FRAC_BITS] < -ONE) ? -ONE : x_r[FRAC_BITS]);
    yc = (y_r[FRAC_BITS] > ONE) ? ONE : ((y_r[FRAC_BITS] < -ONE) ? -ONE : y_r[FRAC_BITS]);
    unique case (quad_r[FRAC_BITS+1])
      QUAD_I: begin
        c_nxt = xc;
        s_nxt = yc;
      end
      QUAD_II: begin
        c_nxt = -yc;
        s_nxt = xc;
      end
      QUAD_III: begin
        c_nxt = -xc;
        s_nxt = -yc;
      end
      default: begin
        c_nxt = yc;
        s_nxt = -xc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= c_nxt[FRAC_BITS+1:0];
      sin_r <= s_nxt[FRAC_BITS+1:0];
    end
  end

  assign cos_q = cos_r;
  assign sin_q = sin_r;

endmodule

[rtl/uv_sphere_vertex_generator_unit.sv]
// uv sphere vertex generator: one vertex (position, normal, texture coordinate) per beat.
// A new beat is taken every clock unless a waiting result is stalled; there are FRAC_BITS + 23 register
// stages: one input stage, 17 restoring-divider stages for u and v, FRAC_BITS + 3 stages of the
// two parallel cordic units, one normal stage and one position stage. A stalled output holds the
// whole pipeline, so in_stall follows out_stall while a result waits. Configuration
// writes are taken at any time and must only happen while no beat is in flight.
// depends on uvs_pkg and uvs_cordic
module uv_sphere_vertex_generator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [10:0]        in_stack_index,
  input  logic [10:0]        in_sector_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] out_pos_x,
  output logic signed [24:0] out_pos_y,
  output logic signed [24:0] out_pos_z,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z,
  output logic [16:0]        out_tex_u,
  output logic [16:0]        out_tex_v,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata
);
  import uvs_pkg::*;

  localparam int IDX_W   = 11;
  localparam int Q_BITS  = 17;
  localparam int NUM_W   = 28;
  localparam int CS_W    = FRAC_BITS + 2;
  localparam int LAT_C   = FRAC_BITS + 3;
  localparam int ST_DIV  = Q_BITS;
  localparam int ST_NRM  = ST_DIV + LAT_C + 1;
  localparam int LAST    = ST_NRM + 1;
  localparam int PW      = 2 * FRAC_BITS + 4;
  localparam int NSH     = 2 * FRAC_BITS - OUT_FRAC;
  localparam int SH_UP   = (FRAC_BITS >= OUT_FRAC) ? 0 : OUT_FRAC - FRAC_BITS;
  localparam int SH_DN   = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int YW      = CS_W + SH_UP + 1;
  localparam int PPW     = 44;

  localparam logic signed [PW-1:0]  NHALF = PW'(longint'(1) << (NSH - 1));
  localparam logic signed [YW-1:0]  YHALF = (SH_DN > 0) ? YW'(longint'(1) << (SH_DN - 1)) : '0;
  localparam logic signed [PPW-1:0] PHALF = PPW'(longint'(1) << (OUT_FRAC - 1));

  logic                 en;
  logic [LAST:0]        vld_r;
  logic [23:0]          radius_r;
  logic [IDX_W-1:0]     sectors_r;
  logic [IDX_W-1:0]     stacks_r;
  logic [IDX_W-1:0]     sec_eff;
  logic [IDX_W-1:0]     stk_eff;
  logic [IDX_W-1:0]     sec_idx;
  logic [IDX_W-1:0]     stk_idx;
  logic [NUM_W-1:0]     unum;
  logic [NUM_W-1:0]     vnum;

  logic [IDX_W-1:0]     urem_r [0:ST_DIV];
  logic [IDX_W-1:0]     vrem_r [0:ST_DIV];
  logic [Q_BITS-1:0]    ulow_r [0:ST_DIV];
  logic [Q_BITS-1:0]    vlow_r [0:ST_DIV];
  logic [Q_BITS-1:0]    uq_r   [0:ST_DIV];
  logic [Q_BITS-1:0]    vq_r   [0:ST_DIV];
  logic [Q_BITS-1:0]    tu_r   [ST_DIV+1:LAST];
  logic [Q_BITS-1:0]    tv_r   [ST_DIV+1:LAST];

  logic [TURN_BITS-1:0] st_turn;
  logic [TURN_BITS-1:0] se_turn;
  logic signed [CS_W-1:0] cst;
  logic signed [CS_W-1:0] sst;
  logic signed [CS_W-1:0] cse;
  logic signed [CS_W-1:0] sse;

  logic signed [PW-1:0]  prod_x;
  logic signed [PW-1:0]  prod_z;
  logic signed [YW-1:0]  y_up;
  logic signed [YW-1:0]  y_rnd;
  logic signed [17:0]    nx_r;
  logic signed [17:0]    ny_r;
  logic signed [17:0]    nz_r;

  logic signed [24:0]    rad_s;
  logic signed [PPW-1:0] px_full;
  logic signed [PPW-1:0] py_full;
  logic signed [PPW-1:0] pz_full;
  logic signed [24:0]    px_r;
  logic signed [24:0]    py_r;
  logic signed [24:0]    pz_r;
  logic signed [17:0]    nx_out_r;
  logic signed [17:0]    ny_out_r;
  logic signed [17:0]    nz_out_r;

  assign en       = !(vld_r[LAST] && out_stall);
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 24'd65536;
      sectors_r <= 11'd48;
      stacks_r  <= 11'd24;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_RADIUS) begin
        radius_r <= cfg_wdata;
      end
      if (cfg_addr == REG_SECTORS) begin
        sectors_r <= cfg_wdata[IDX_W-1:0];
      end
      if (cfg_addr == REG_STACKS) begin
        stacks_r <= cfg_wdata[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // clamp and form rounded dividends
  always_comb begin
    sec_eff = (sectors_r == '0) ? IDX_W'(1) : sectors_r;
    stk_eff = (stacks_r == '0) ? IDX_W'(1) : stacks_r;
    sec_idx = (in_sector_index > sec_eff) ? sec_eff : in_sector_index;
    stk_idx = (in_stack_index > stk_eff) ? stk_eff : in_stack_index;
    unum    = (NUM_W'(sec_idx) << OUT_FRAC) + NUM_W'(sec_eff >> 1);
    vnum    = (NUM_W'(stk_idx) << OUT_FRAC) + NUM_W'(stk_eff >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      urem_r[0] <= IDX_W'(unum >> Q_BITS);
      vrem_r[0] <= IDX_W'(vnum >> Q_BITS);
      ulow_r[0] <= unum[Q_BITS-1:0];
      vlow_r[0] <= vnum[Q_BITS-1:0];
      uq_r[0]   <= '0;
      vq_r[0]   <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 1; g <= ST_DIV; g++) begin : g_div
    logic [IDX_W:0]   ut;
    logic [IDX_W:0]   vt;
    logic [IDX_W:0]   ud;
    logic [IDX_W:0]   vd;
    logic             uge;
    logic             vge;
    always_comb begin
      ut  = {urem_r[g-1], ulow_r[g-1][Q_BITS-g]};
      vt  = {vrem_r[g-1], vlow_r[g-1][Q_BITS-g]};
      uge = ut >= {1'b0, sec_eff};
      vge = vt >= {1'b0, stk_eff};
      ud  = uge ? ut - {1'b0, sec_eff} : ut;
      vd  = vge ? vt - {1'b0, stk_eff} : vt;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        urem_r[g] <= ud[IDX_W-1:0];
        vrem_r[g] <= vd[IDX_W-1:0];
        ulow_r[g] <= ulow_r[g-1];
        vlow_r[g] <= vlow_r[g-1];
        uq_r[g]   <= {uq_r[g-1][Q_BITS-2:0], uge};
        vq_r[g]   <= {vq_r[g-1][Q_BITS-2:0], vge};
      end
    end
  end

  // angles in turns
  assign se_turn = {uq_r[ST_DIV][TURN_BITS-2:0], 1'b0};
  assign st_turn = QUARTER_TURN - vq_r[ST_DIV];

  uvs_cordic #(.FRAC_BITS(FRAC_BITS)) u_stack_cs (
    .clk   (clk),
    .en    (en),
    .turn  (st_turn),
    .cos_q (cst),
    .sin_q (sst)
  );

  uvs_cordic #(.FRAC_BITS(FRAC_BITS)) u_sector_cs (
    .clk   (clk),
    .en    (en),
    .turn  (se_turn),
    .cos_q (cse),
    .sin_q (sse)
  );

  // texture coordinates ride along
  for (genvar g = ST_DIV + 1; g <= LAST; g++) begin : g_tex
    if (g == ST_DIV + 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          tu_r[g] <= uq_r[ST_DIV];
          tv_r[g] <= vq_r[ST_DIV];
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          tu_r[g] <= tu_r[g-1];
          tv_r[g] <= tv_r[g-1];
        end
      end
    end
  end

  // unit normal
  always_comb begin
    prod_x = PW'(cst) * PW'(cse);
    prod_z = PW'(cst) * PW'(sse);
    y_up   = YW'(sst) <<< SH_UP;
    y_rnd  = (y_up + YHALF) >>> SH_DN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= 18'((prod_x + NHALF) >>> NSH);
      nz_r <= 18'((prod_z + NHALF) >>> NSH);
      ny_r <= y_rnd[17:0];
    end
  end

  // position
  always_comb begin
    rad_s   = {1'b0, radius_r};
    px_full = (PPW'(nx_r) * PPW'(rad_s) + PHALF) >>> OUT_FRAC;
    py_full = (PPW'(ny_r) * PPW'(rad_s) + PHALF) >>> OUT_FRAC;
    pz_full = (PPW'(nz_r) * PPW'(rad_s) + PHALF) >>> OUT_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= px_full[24:0];
      py_r     <= py_full[24:0];
      pz_r     <= pz_full[24:0];
      nx_out_r <= nx_r;
      ny_out_r <= ny_r;
      nz_out_r <= nz_r;
    end
  end

  assign out_valid    = vld_r[LAST];
  assign out_pos_x    = px_r;
  assign out_pos_y    = py_r;
  assign out_pos_z    = pz_r;
  assign out_normal_x = nx_out_r;
  assign out_normal_y = ny_out_r;
  assign out_normal_z = nz_out_r;
  assign out_tex_u    = tu_r[LAST];
  assign out_tex_v    = tv_r[LAST];

endmodule

[rtl/uvs_checker.sv]
// port-level checks of the uv sphere vertex generator, bound to the top level
// depends on uv_sphere_vertex_generator_unit_macros.svh
`include "uv_sphere_vertex_generator_unit_macros.svh"

module uvs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [24:0] out_pos_x,
  input logic signed [17:0] out_normal_y,
  input logic [16:0]        out_tex_u,
  input logic [16:0]        out_tex_v
);

  logic held;
  logic tex_ok;
  logic ny_ok;

  assign held   = out_valid && out_stall;
  assign tex_ok = (out_tex_u <= 17'd65536) && (out_tex_v <= 17'd65536);
  assign ny_ok  = (out_normal_y <= 18'sd65536) && (out_normal_y >= -18'sd65536);

  `UVS_ASSERT_NXT(a_out_hold, held, out_valid, "result beat dropped while stalled")
  `UVS_ASSERT_NXT(a_stable, held, $stable(out_tex_u) && $stable(out_pos_x), "stalled beat changed")
  `UVS_ASSERT_IMP(a_in_stall_cause, in_stall, held, "input stalled without a waiting result")
  `UVS_ASSERT_IMP(a_ranges, out_valid, tex_ok && ny_ok, "result out of range")

endmodule

bind uv_sphere_vertex_generator_unit uvs_checker u_uvs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_pos_x    (out_pos_x),
  .out_normal_y (out_normal_y),
  .out_tex_u    (out_tex_u),
  .out_tex_v    (out_tex_v)
);

[dv/tb_uv_sphere_vertex_generator_unit.sv]
// testbench for uv_sphere_vertex_generator_unit: random and directed grid points,
// checked field by field against a behavioral vertex predictor in a scoreboard class
// depends on uvs_pkg and the rtl of the generator
module tb_uv_sphere_vertex_generator_unit;
  import uvs_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = FB + 23;

  typedef struct packed {
    logic signed [24:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
    logic [16:0] tu, tv;
  } vertex_t;

  class vertex_scoreboard;
    longint radius;
    longint sectors;
    longint stacks;
    vertex_t pending[$];
    int errors;
    int checked;

    function new();
      radius = 65536;
      sectors = 48;
      stacks = 24;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [23:0] val);
      case (idx)
        REG_RADIUS:  radius = longint'(val);
        REG_SECTORS: sectors = longint'(val[10:0]);
        REG_STACKS:  stacks = longint'(val[10:0]);
        default: ;
      endcase
    endfunction

    function longint fshift(longint v, int k);
      return v >>> k;
    endfunction

    function longint rshift(longint v, int k);
      if (k == 0) return v;
      return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function longint unit_clamp(longint v);
      longint one;
      one = longint'(1) << FB;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
    endfunction

    function longint frac_of(longint idx, longint cnt);
      if (cnt == 0) cnt = 1;
      if (idx > cnt) idx = cnt;
      return ((idx << 16) + (cnt >> 1)) / cnt;
    endfunction

    function void turn_sin_cos(longint t, output longint c, output longint s);
      longint quad, rem, z, x, y, a, dx, dy;
      int sh;
      quad = (t >> 15) & 3;
      rem = t & 32'h7fff;
      sh = 32 + 17 - FB;
      z = (rem * TWO_PI_Q32 + (longint'(1) << (sh - 1))) >> sh;
      x = rshift(GAIN_Q30, 30 - FB);
      y = 0;
      for (int k = 0; k < FB; k++) begin
        a = rshift(ATAN_Q30[k], 30 - FB);
        dx = fshift(y, k);
        dy = fshift(x, k);
        if (z >= 0) begin
          x -= dx; y += dy; z -= a;
        end else begin
          x += dx; y -= dy; z += a;
        end
      end
      x = unit_clamp(x);
      y = unit_clamp(y);
      case (quad)
        0: begin c = x; s = y; end
        1: begin c = -y; s = x; end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void note_point(logic [10:0] stk, logic [10:0] sec);
      longint u, v, stt, set, cst, sst, cse, sse, nx, ny, nz;
      vertex_t e;
      v = frac_of(longint'(stk), stacks);
      u = frac_of(longint'(sec), sectors);
      stt = (32'h8000 + (1 << 17) - v) & 32'h1ffff;
      set = (u << 1) & 32'h1ffff;
      turn_sin_cos(stt, cst, sst);
      turn_sin_cos(set, cse, sse);
      nx = rshift(cst * cse, 2 * FB - 16);
      nz = rshift(cst * sse, 2 * FB - 16);
      ny = rshift(sst, FB - 16);
      e.px = 25'(rshift(nx * radius, 16));
      e.py = 25'(rshift(ny * radius, 16));
      e.pz = 25'(rshift(nz * radius, 16));
      e.nx = 18'(nx); e.ny = 18'(ny); e.nz = 18'(nz);
      e.tu = 17'(u); e.tv = 17'(v);
      pending = {pending, e};
    endfunction

    function void report(string f, longint e, longint a);
      $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
      errors++;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.px !== e.px) report("pos_x", longint'(e.px), longint'(got.px));
      if (got.py !== e.py) report("pos_y", longint'(e.py), longint'(got.py));
      if (got.pz !== e.pz) report("pos_z", longint'(e.pz), longint'(got.pz));
      if (got.nx !== e.nx) report("normal_x", longint'(e.nx), longint'(got.nx));
      if (got.ny !== e.ny) report("normal_y", longint'(e.ny), longint'(got.ny));
      if (got.nz !== e.nz) report("normal_z", longint'(e.nz), longint'(got.nz));
      if (got.tu !== e.tu) report("tex_u", longint'(e.tu), longint'(got.tu));
      if (got.tv !== e.tv) report("tex_v", longint'(e.tv), longint'(got.tv));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [10:0] in_stack_index = '0;
  logic [10:0] in_sector_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [24:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [17:0] out_normal_x, out_normal_y, out_normal_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int sent = 0;
  vertex_scoreboard sb;

  uv_sphere_vertex_generator_unit #(.FRAC_BITS(FB)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: stall pattern and result checking
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_vertex({out_pos_x, out_pos_y, out_pos_z, out_normal_x, out_normal_y,
                       out_normal_z, out_tex_u, out_tex_v});
  end

  task automatic send_point(logic [10:0] stk, logic [10:0] sec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_stack_index <= stk;
    in_sector_index <= sec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(stk, sec);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_shape(logic [23:0] r, logic [10:0] se, logic [10:0] st);
    write_reg(REG_RADIUS, r);
    write_reg(REG_SECTORS, 24'(se));
    write_reg(REG_STACKS, 24'(st));
  endtask

  // mostly in-range indices, some clamped and full-width
  task automatic random_points(int n);
    logic [10:0] a, b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) begin
        a = 11'($urandom_range(32'(sb.stacks)));
        b = 11'($urandom_range(32'(sb.sectors)));
      end else begin
        a = 11'($urandom);
        b = 11'($urandom);
      end
      send_point(a, b);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: poles, equator, clamped and extreme indices
    send_point(11'd0, 11'd0);
    send_point(11'd24, 11'd48);
    send_point(11'd12, 11'd12);
    send_point(11'd6, 11'd36);
    send_point(11'h7ff, 11'h7ff);
    send_point(11'd1024, 11'd1024);
    send_point(11'd18, 11'd24);
    send_point(11'd3, 11'd5);
    drain();
    set_shape(24'hffffff, 11'd1024, 11'd1024);
    send_point(11'd512, 11'd256);
    send_point(11'd1, 11'd1023);
    send_point(11'd1023, 11'd1);
    send_point(11'h555, 11'h2aa);
    send_point(11'h2aa, 11'h555);
    drain();
    set_shape(24'd0, 11'd0, 11'd0);
    send_point(11'd0, 11'd0);
    send_point(11'd1, 11'd1);
    send_point(11'd5, 11'd9);
    drain();
    set_shape(24'd1, 11'd2047, 11'd2047);
    send_point(11'd2047, 11'd2047);
    send_point(11'd1024, 11'd512);
    send_point(11'd100, 11'd1900);
    drain();

    set_shape(24'h0a3c5e, 11'd32, 11'd16);
    random_points(100);
    drain();

    set_shape(24'h5a5a5a, 11'd7, 11'd1);
    send_idle_pct = 87;
    random_points(60);
    drain();

    set_shape(24'h123456, 11'd1000, 11'd3);
    send_idle_pct = 0;
    recv_stall_pct = 87;
    random_points(80);
    drain();

    set_shape(24'hf00f00, 11'd17, 11'd1024);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    random_points(80);
    // long receiver hold while the sender keeps offering beats
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3 * LATENCY;
    random_points(100);
    drain();

    $display("checked %0d vertices from %0d beats over several radius and grid settings",
             sb.checked, sent);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
